>>> hdl/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg: shared types and constants of the cut merge unit
// Field widths, the transaction structs of both channels and the payload
// structs that travel between the pipeline stages.
// ----------------------------------------------------------------------------
package lcm_pkg;

  // Cut geometry.
  localparam int MAX_LEAVES   = 5;
  localparam int LEAF_ID_BITS = 12;
  localparam int LEVEL_BITS   = 8;
  localparam int AREA_BITS    = 12;

  // Derived widths.
  localparam int CNT_W      = 3;
  localparam int LUT_SIZE_W = 3;
  localparam int ROOT_W     = 4;
  localparam int IDS_W      = MAX_LEAVES * LEAF_ID_BITS;
  localparam int LEVS_W     = MAX_LEAVES * LEVEL_BITS;
  localparam int AREAS_W    = MAX_LEAVES * AREA_BITS;
  localparam int TRUTH_W    = 1 << MAX_LEAVES;
  localparam int M_W        = $clog2(2 * MAX_LEAVES + 1);
  localparam int POS_W      = $clog2(2 * MAX_LEAVES);
  localparam int SEL_W      = $clog2(MAX_LEAVES);
  localparam int SUM_W      = AREA_BITS + $clog2(MAX_LEAVES + 1);

  localparam logic [LUT_SIZE_W-1:0] LUT_SIZE_RESET = LUT_SIZE_W'(4);
  localparam logic [CNT_W-1:0]      MAX_CNT        = CNT_W'(MAX_LEAVES);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX      = {LEVEL_BITS{1'b1}};
  localparam logic [AREA_BITS-1:0]  AREA_MAX       = {AREA_BITS{1'b1}};

  // Per-leaf vectors; entry i sits at bit i times the entry width.
  typedef logic [MAX_LEAVES-1:0][LEAF_ID_BITS-1:0] id_vec_t;
  typedef logic [MAX_LEAVES-1:0][LEVEL_BITS-1:0]   lev_vec_t;
  typedef logic [MAX_LEAVES-1:0][AREA_BITS-1:0]    area_vec_t;
  typedef logic [MAX_LEAVES-1:0][POS_W-1:0]        pos_vec_t;
  typedef logic [MAX_LEAVES-1:0][MAX_LEAVES-1:0]   eq_mat_t;

  // Input transaction.
  typedef struct packed {
    logic [IDS_W-1:0]   a_leaf_ids;
    logic [CNT_W-1:0]   a_leaf_count;
    logic [TRUTH_W-1:0] a_truth;
    logic [LEVS_W-1:0]  a_leaf_levels;
    logic [AREAS_W-1:0] a_leaf_areas;
    logic [IDS_W-1:0]   b_leaf_ids;
    logic [CNT_W-1:0]   b_leaf_count;
    logic [TRUTH_W-1:0] b_truth;
    logic [LEVS_W-1:0]  b_leaf_levels;
    logic [AREAS_W-1:0] b_leaf_areas;
    logic [ROOT_W-1:0]  root_function;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic               cut_valid;
    logic [IDS_W-1:0]   merged_leaf_ids;
    logic [M_W-1:0]     merged_count;
    logic [TRUTH_W-1:0] merged_truth;
    logic [LEVEL_BITS-1:0] cut_level;
    logic [AREA_BITS-1:0]  cut_area;
  } out_item_t;

  // After leaf id comparison.
  typedef struct packed {
    id_vec_t            a_ids;
    id_vec_t            b_ids;
    lev_vec_t           a_lev;
    lev_vec_t           b_lev;
    area_vec_t          a_area;
    area_vec_t          b_area;
    logic [TRUTH_W-1:0] a_truth;
    logic [TRUTH_W-1:0] b_truth;
    logic [ROOT_W-1:0]  root;
    logic [MAX_LEAVES-1:0] a_en;
    logic [MAX_LEAVES-1:0] b_en;
    eq_mat_t            a_eq_a;
    eq_mat_t            b_eq_a;
    eq_mat_t            b_eq_b;
  } s1_t;

  // After merged position assignment.
  typedef struct packed {
    id_vec_t            a_ids;
    id_vec_t            b_ids;
    lev_vec_t           a_lev;
    lev_vec_t           b_lev;
    area_vec_t          a_area;
    area_vec_t          b_area;
    logic [TRUTH_W-1:0] a_truth;
    logic [TRUTH_W-1:0] b_truth;
    logic [ROOT_W-1:0]  root;
    logic [MAX_LEAVES-1:0] a_en;
    logic [MAX_LEAVES-1:0] b_en;
    logic [MAX_LEAVES-1:0] a_new;
    logic [MAX_LEAVES-1:0] b_new;
    pos_vec_t           a_pos;
    pos_vec_t           b_pos;
    logic [M_W-1:0]     m;
    logic               cut_valid;
  } s2_t;

  // After compaction and truth table composition.
  typedef struct packed {
    id_vec_t            ids;
    lev_vec_t           lev;
    area_vec_t          area;
    logic [TRUTH_W-1:0] truth;
    logic [M_W-1:0]     m;
    logic               cut_valid;
  } s3_t;

endpackage

>>> hdl/lcm_match.sv
// ----------------------------------------------------------------------------
// lcm_match: leaf id comparison stage
// Clamps the leaf counts and compares every pair of leaf ids that the merge
// needs, registering the equality matrices with the transaction.
// ----------------------------------------------------------------------------
module lcm_match (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  lcm_pkg::in_item_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output lcm_pkg::s1_t      dn_data
);
  import lcm_pkg::*;

  logic             valid_r;
  s1_t              data_r;
  s1_t              data_nxt;
  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;

  // Counts above the leaf limit act as the limit.
  assign cnt_a = (up_data.a_leaf_count > MAX_CNT) ? MAX_CNT : up_data.a_leaf_count;
  assign cnt_b = (up_data.b_leaf_count > MAX_CNT) ? MAX_CNT : up_data.b_leaf_count;

  // Leaf enables and pairwise id equality.
  always_comb begin
    data_nxt.a_ids   = up_data.a_leaf_ids;
    data_nxt.b_ids   = up_data.b_leaf_ids;
    data_nxt.a_lev   = up_data.a_leaf_levels;
    data_nxt.b_lev   = up_data.b_leaf_levels;
    data_nxt.a_area  = up_data.a_leaf_areas;
    data_nxt.b_area  = up_data.b_leaf_areas;
    data_nxt.a_truth = up_data.a_truth;
    data_nxt.b_truth = up_data.b_truth;
    data_nxt.root    = up_data.root_function;
    for (int j = 0; j < MAX_LEAVES; j++) begin
      data_nxt.a_en[j] = CNT_W'(j) < cnt_a;
      data_nxt.b_en[j] = CNT_W'(j) < cnt_b;
    end
    for (int j = 0; j < MAX_LEAVES; j++) begin
      for (int k = 0; k < MAX_LEAVES; k++) begin
        data_nxt.a_eq_a[j][k] = (k < j) && data_nxt.a_en[j] && data_nxt.a_en[k] &&
                                (data_nxt.a_ids[j] == data_nxt.a_ids[k]);
        data_nxt.b_eq_a[j][k] = data_nxt.b_en[j] && data_nxt.a_en[k] &&
                                (data_nxt.b_ids[j] == data_nxt.a_ids[k]);
        data_nxt.b_eq_b[j][k] = (k < j) && data_nxt.b_en[j] && data_nxt.b_en[k] &&
                                (data_nxt.b_ids[j] == data_nxt.b_ids[k]);
      end
    end
  end

  // Stage handshake.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/lcm_place.sv
// ----------------------------------------------------------------------------
// lcm_place: merged position stage
// Marks the leaves that enter the merged list, gives every enabled leaf its
// position in that list, and checks the merged count against the LUT size.
// ----------------------------------------------------------------------------
module lcm_place (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lcm_pkg::LUT_SIZE_W-1:0]    lut_size,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  lcm_pkg::s1_t                      up_data,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output lcm_pkg::s2_t                      dn_data
);
  import lcm_pkg::*;

  logic                  valid_r;
  s2_t                   data_r;
  s2_t                   data_nxt;
  logic [LUT_SIZE_W-1:0] limit;

  assign limit = (lut_size > LUT_SIZE_W'(MAX_LEAVES)) ? LUT_SIZE_W'(MAX_LEAVES) : lut_size;

  // A leaf seen before reuses the position of its first occurrence.
  always_comb begin
    logic [M_W-1:0] run;
    run = '0;
    data_nxt.a_ids   = up_data.a_ids;
    data_nxt.b_ids   = up_data.b_ids;
    data_nxt.a_lev   = up_data.a_lev;
    data_nxt.b_lev   = up_data.b_lev;
    data_nxt.a_area  = up_data.a_area;
    data_nxt.b_area  = up_data.b_area;
    data_nxt.a_truth = up_data.a_truth;
    data_nxt.b_truth = up_data.b_truth;
    data_nxt.root    = up_data.root;
    data_nxt.a_en    = up_data.a_en;
    data_nxt.b_en    = up_data.b_en;
    for (int j = 0; j < MAX_LEAVES; j++) begin
      data_nxt.a_new[j] = up_data.a_en[j] && !(|up_data.a_eq_a[j]);
      data_nxt.a_pos[j] = '0;
      if (data_nxt.a_new[j]) begin
        data_nxt.a_pos[j] = POS_W'(run);
        run = run + M_W'(1);
      end else begin
        for (int k = MAX_LEAVES - 1; k >= 0; k--) begin
          if (up_data.a_eq_a[j][k]) begin
            data_nxt.a_pos[j] = data_nxt.a_pos[k];
          end
        end
      end
    end
    for (int j = 0; j < MAX_LEAVES; j++) begin
      data_nxt.b_new[j] = up_data.b_en[j] && !(|up_data.b_eq_a[j]) &&
                          !(|up_data.b_eq_b[j]);
      data_nxt.b_pos[j] = '0;
      if (data_nxt.b_new[j]) begin
        data_nxt.b_pos[j] = POS_W'(run);
        run = run + M_W'(1);
      end else begin
        for (int k = MAX_LEAVES - 1; k >= 0; k--) begin
          if (up_data.b_eq_b[j][k]) begin
            data_nxt.b_pos[j] = data_nxt.b_pos[k];
          end
        end
        for (int k = MAX_LEAVES - 1; k >= 0; k--) begin
          if (up_data.b_eq_a[j][k]) begin
            data_nxt.b_pos[j] = data_nxt.a_pos[k];
          end
        end
      end
    end
    data_nxt.m         = run;
    data_nxt.cut_valid = run <= M_W'(limit);
  end

  // Stage handshake.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/lcm_compose.sv
// ----------------------------------------------------------------------------
// lcm_compose: compaction and truth table stage
// Gathers the merged leaves into their slots and composes the merged truth
// table through the root function, one minterm per lane.
// ----------------------------------------------------------------------------
module lcm_compose (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  lcm_pkg::s2_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output lcm_pkg::s3_t dn_data
);
  import lcm_pkg::*;

  logic               valid_r;
  s3_t                data_r;
  s3_t                data_nxt;
  logic [TRUTH_W-1:0] truth_nxt;

  // Each slot takes the one new leaf placed there; empty slots stay zero.
  always_comb begin
    data_nxt.ids       = '0;
    data_nxt.lev       = '0;
    data_nxt.area      = '0;
    data_nxt.truth     = truth_nxt;
    data_nxt.m         = up_data.m;
    data_nxt.cut_valid = up_data.cut_valid;
    for (int k = 0; k < MAX_LEAVES; k++) begin
      for (int j = 0; j < MAX_LEAVES; j++) begin
        if (up_data.a_new[j] && (up_data.a_pos[j] == POS_W'(k))) begin
          data_nxt.ids[k]  = data_nxt.ids[k]  | up_data.a_ids[j];
          data_nxt.lev[k]  = data_nxt.lev[k]  | up_data.a_lev[j];
          data_nxt.area[k] = data_nxt.area[k] | up_data.a_area[j];
        end
        if (up_data.b_new[j] && (up_data.b_pos[j] == POS_W'(k))) begin
          data_nxt.ids[k]  = data_nxt.ids[k]  | up_data.b_ids[j];
          data_nxt.lev[k]  = data_nxt.lev[k]  | up_data.b_lev[j];
          data_nxt.area[k] = data_nxt.area[k] | up_data.b_area[j];
        end
      end
    end
  end

  // For every merged minterm, look up both cuts on their own leaves and feed
  // the two bits to the root. Minterms >= 2**m and invalid cuts are zero.
  always_comb begin
    logic [MAX_LEAVES-1:0] mt;
    logic [MAX_LEAVES-1:0] ia;
    logic [MAX_LEAVES-1:0] ib;
    logic                  ra;
    logic                  rb;
    truth_nxt = '0;
    for (int st = 0; st < TRUTH_W; st++) begin
      mt = MAX_LEAVES'(st);
      ia = '0;
      ib = '0;
      for (int j = 0; j < MAX_LEAVES; j++) begin
        if (up_data.a_en[j] && (up_data.a_pos[j] < POS_W'(MAX_LEAVES))) begin
          ia[j] = mt[up_data.a_pos[j][SEL_W-1:0]];
        end
        if (up_data.b_en[j] && (up_data.b_pos[j] < POS_W'(MAX_LEAVES))) begin
          ib[j] = mt[up_data.b_pos[j][SEL_W-1:0]];
        end
      end
      ra = up_data.a_truth[ia];
      rb = up_data.b_truth[ib];
      truth_nxt[st] = up_data.root[{rb, ra}] && up_data.cut_valid &&
                      ((mt >> up_data.m) == '0);
    end
  end

  // Stage handshake.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/lcm_cost.sv
// ----------------------------------------------------------------------------
// lcm_cost: level and area stage
// Takes the largest leaf level and the sum of leaf areas, adds one with
// saturation, and registers the finished result transaction.
// ----------------------------------------------------------------------------
module lcm_cost (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  lcm_pkg::s3_t       up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output lcm_pkg::out_item_t dn_data
);
  import lcm_pkg::*;

  logic                  valid_r;
  out_item_t             data_r;
  out_item_t             data_nxt;
  logic [LEVEL_BITS-1:0] lev_max;
  logic [SUM_W-1:0]      area_sum;

  // Empty slots hold zero, so they add nothing to the max or the sum.
  always_comb begin
    lev_max  = '0;
    area_sum = '0;
    for (int k = 0; k < MAX_LEAVES; k++) begin
      if (up_data.lev[k] > lev_max) begin
        lev_max = up_data.lev[k];
      end
      area_sum = area_sum + SUM_W'(up_data.area[k]);
    end
  end

  // Saturating plus one; invalid cuts report zero cost.
  always_comb begin
    data_nxt.cut_valid       = up_data.cut_valid;
    data_nxt.merged_leaf_ids = up_data.ids;
    data_nxt.merged_count    = up_data.m;
    data_nxt.merged_truth    = up_data.truth;
    data_nxt.cut_level       = '0;
    data_nxt.cut_area        = '0;
    if (up_data.cut_valid) begin
      data_nxt.cut_level = (lev_max == LEVEL_MAX) ? LEVEL_MAX : lev_max + LEVEL_BITS'(1);
      data_nxt.cut_area  = (area_sum >= SUM_W'(AREA_MAX)) ? AREA_MAX :
                           AREA_BITS'(area_sum) + AREA_BITS'(1);
    end
  end

  // Output register handshake.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/lut_cut_merge_truth_table_unit.sv
// ----------------------------------------------------------------------------
// lut_cut_merge_truth_table_unit: cut merge with truth table composition
// Merges two fanin cuts of an AND-inverter node into one LUT cut and gives
// its feasibility, leaf list, truth table, level and area.
// ----------------------------------------------------------------------------
// The unit accepts one cut pair per clock cycle while in_ready is high and
// returns one result per pair on out_valid, in order. The four register stages
// (id comparison, position assignment, compaction with truth composition,
// level and area) each hold one transaction; a stalled output fills the
// stages behind it before in_ready falls. lut_size is written through
// cfg_we and cfg_wdata and resets to four; the user must write it only
// while the unit is empty, as the unit itself does not enforce this.
module lut_cut_merge_truth_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lcm_pkg::LUT_SIZE_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lcm_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lcm_pkg::out_item_t             out_data
);
  import lcm_pkg::*;

  logic [LUT_SIZE_W-1:0] lut_size_r;
  logic                  s1_valid;
  logic                  s1_ready;
  s1_t                   s1_data;
  logic                  s2_valid;
  logic                  s2_ready;
  s2_t                   s2_data;
  logic                  s3_valid;
  logic                  s3_ready;
  s3_t                   s3_data;

  // LUT size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_size_r <= LUT_SIZE_RESET;
    end else if (cfg_we) begin
      lut_size_r <= cfg_wdata;
    end
  end

  // Pipeline stages.
  lcm_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  lcm_place u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .lut_size (lut_size_r),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  lcm_compose u_compose (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  lcm_cost u_cost (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

>>> hdl/lcm_checker.sv
// ----------------------------------------------------------------------------
// lcm_checker: port-level checks of the cut merge unit
// Watches the result channel for reset behavior, stall stability and the
// consistency of the fields of an invalid or valid cut.
// ----------------------------------------------------------------------------
module lcm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               out_valid,
  input  logic               out_ready,
  input  lcm_pkg::out_item_t out_data
);
  import lcm_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // An infeasible cut carries no table and no cost.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cut_valid |->
      out_data.merged_truth == '0 && out_data.cut_level == '0 && out_data.cut_area == '0)
    else $error("invalid cut with nonzero table or cost");

  // A feasible cut has at most the leaf limit and a nonzero level and area.
  a_valid_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cut_valid |->
      out_data.merged_count <= M_W'(MAX_LEAVES) &&
      out_data.cut_level != '0 && out_data.cut_area != '0)
    else $error("valid cut with bad count or zero cost");

endmodule

bind lut_cut_merge_truth_table_unit lcm_checker u_lcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
